FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

FILE: sv/mcd_pkg.sv
package mcd_pkg;

    localparam int BUTTON_COUNT_DEF = 8;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);

    localparam logic [2:0] OP_X      = 3'd0;
    localparam logic [2:0] OP_Y      = 3'd1;
    localparam logic [2:0] OP_WHEEL  = 3'd2;
    localparam logic [2:0] OP_BUTTON = 3'd3;
    localparam logic [2:0] OP_FRAME  = 3'd4;

    localparam logic [2:0] EV_DOWN   = 3'd0;
    localparam logic [2:0] EV_UP     = 3'd1;
    localparam logic [2:0] EV_STROKE = 3'd2;
    localparam logic [2:0] EV_DOUBLE = 3'd3;
    localparam logic [2:0] EV_WHEEL  = 3'd4;
    localparam logic [2:0] EV_MOVE   = 3'd5;

    localparam logic [3:0] NO_BUTTON = 4'd8;

    localparam logic [1:0] CFG_DBL_WINDOW = 2'd0;
    localparam logic [1:0] CFG_HOLD_TIME  = 2'd1;
    localparam logic [1:0] CFG_TRAVEL     = 2'd2;

    localparam logic [15:0] DBL_WINDOW_RST = 16'd300;
    localparam logic [15:0] HOLD_TIME_RST  = 16'd500;
    localparam logic [15:0] TRAVEL_RST     = 16'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [2:0]         button;
        logic               pressed;
        logic signed [15:0] amount;
        logic [31:0]        stamp;
    } item_t;

    typedef struct packed {
        logic [2:0]         event_code;
        logic [3:0]         event_button;
        logic signed [15:0] wheel_delta;
        logic signed [31:0] total_x;
        logic signed [31:0] total_y;
        logic signed [31:0] total_wheel;
        logic               drag_active;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [15:0] dbl_window;
        logic [15:0] hold_time;
        logic [15:0] travel;
    } cfg_t;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [15:0] b);
        logic [32:0] s;
        s = {a[31], a} + {{17{b[15]}}, b};
        if (s[32] != s[31])
        begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[31:0];
    endfunction

endpackage

FILE: sv/mcd_core.sv
`include "assert_macros.svh"

module mcd_core #(
    parameter int BUTTON_COUNT = mcd_pkg::BUTTON_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  mcd_pkg::item_t  item,
    input  mcd_pkg::cfg_t   cfg,
    output mcd_pkg::result_t res0,
    output mcd_pkg::result_t res1,
    output logic [1:0]      res_count
);

    localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    logic [BUTTON_COUNT-1:0] held_flags_reg, held_flags_next;
    logic [BUTTON_COUNT-1:0] click_flags_reg, click_flags_next;
    logic [31:0]             press_times_reg [BUTTON_COUNT];
    logic [2:0]              drag_button_reg, drag_button_next;
    logic                    pre_drag_reg, pre_drag_next;
    logic                    drag_reg, drag_next;
    logic [15:0]             travel_reg, travel_next;
    logic [3:0]              last_rel_btn_reg, last_rel_btn_next;
    logic [31:0]             last_rel_time_reg, last_rel_time_next;
    logic signed [31:0]      sum_x_reg, sum_x_next;
    logic signed [31:0]      sum_y_reg, sum_y_next;
    logic signed [31:0]      sum_wheel_reg, sum_wheel_next;
    logic                    moved_reg, moved_next;

    logic [IDX_W-1:0] bidx;
    logic [IDX_W-1:0] drag_idx;
    logic             btn_ok;
    logic             press_wr;
    logic [16:0]      mag;
    logic [17:0]      travel_sum;
    logic [15:0]      travel_sat;
    logic [31:0]      held_for;
    logic             drag_start;
    logic             dbl_hit;
    logic [1:0]       n_res;

    assign bidx     = item.button[IDX_W-1:0];
    assign drag_idx = drag_button_reg[IDX_W-1:0];
    assign btn_ok   = {1'b0, item.button} < 4'(BUTTON_COUNT);

    assign mag        = item.amount[15] ? 17'(-{item.amount[15], item.amount})
                                        : {1'b0, item.amount};
    assign travel_sum = 18'(travel_reg) + 18'(mag);
    assign travel_sat = (travel_sum[17:16] != 2'b00) ? 16'hFFFF : travel_sum[15:0];
    assign held_for   = item.stamp - press_times_reg[drag_idx];
    assign drag_start = (held_for > {16'b0, cfg.hold_time}) || (travel_sat >= cfg.travel);
    assign dbl_hit    = ({1'b0, item.button} == last_rel_btn_reg) &&
                        ((item.stamp - last_rel_time_reg) < {16'b0, cfg.dbl_window});

    always_comb
    begin
        held_flags_next    = held_flags_reg;
        click_flags_next   = click_flags_reg;
        drag_button_next   = drag_button_reg;
        pre_drag_next      = pre_drag_reg;
        drag_next          = drag_reg;
        travel_next        = travel_reg;
        last_rel_btn_next  = last_rel_btn_reg;
        last_rel_time_next = last_rel_time_reg;
        sum_x_next         = sum_x_reg;
        sum_y_next         = sum_y_reg;
        sum_wheel_next     = sum_wheel_reg;
        moved_next         = moved_reg;
        press_wr           = 1'b0;
        n_res              = 2'd0;
        res0               = '0;
        res1               = '0;
        res0.event_button  = mcd_pkg::NO_BUTTON;
        res1.event_button  = mcd_pkg::NO_BUTTON;

        unique case (item.operation)
            mcd_pkg::OP_X, mcd_pkg::OP_Y:
            begin
                if (item.operation == mcd_pkg::OP_X)
                begin
                    sum_x_next = mcd_pkg::sat_add(sum_x_reg, item.amount);
                end
                else
                begin
                    sum_y_next = mcd_pkg::sat_add(sum_y_reg, item.amount);
                end
                moved_next = 1'b1;
                if (pre_drag_reg)
                begin
                    travel_next = travel_sat;
                    if (drag_start)
                    begin
                        pre_drag_next = 1'b0;
                        drag_next     = 1'b1;
                    end
                end
            end
            mcd_pkg::OP_WHEEL:
            begin
                sum_wheel_next   = mcd_pkg::sat_add(sum_wheel_reg, item.amount);
                res0.event_code  = mcd_pkg::EV_WHEEL;
                res0.wheel_delta = item.amount;
                n_res            = 2'd1;
            end
            mcd_pkg::OP_BUTTON:
            begin
                if (btn_ok)
                begin
                    res0.event_button = {1'b0, item.button};
                    res1.event_button = {1'b0, item.button};
                    if (item.pressed)
                    begin
                        held_flags_next[bidx]  = 1'b1;
                        click_flags_next[bidx] = 1'b1;
                        press_wr               = 1'b1;
                        if (!drag_reg)
                        begin
                            drag_button_next = item.button;
                            pre_drag_next    = 1'b1;
                            travel_next      = '0;
                        end
                        res0.event_code = mcd_pkg::EV_DOWN;
                        n_res           = 2'd1;
                    end
                    else
                    begin
                        held_flags_next[bidx] = 1'b0;
                        drag_next             = 1'b0;
                        pre_drag_next         = 1'b0;
                        if (dbl_hit)
                        begin
                            res0.event_code   = mcd_pkg::EV_DOUBLE;
                            n_res             = 2'd1;
                            last_rel_btn_next = mcd_pkg::NO_BUTTON;
                        end
                        else
                        begin
                            res0.event_code    = mcd_pkg::EV_UP;
                            res1.event_code    = mcd_pkg::EV_STROKE;
                            n_res              = drag_reg ? 2'd1 : 2'd2;
                            last_rel_btn_next  = {1'b0, item.button};
                            last_rel_time_next = item.stamp;
                        end
                    end
                end
            end
            mcd_pkg::OP_FRAME:
            begin
                if (moved_reg)
                begin
                    res0.event_code  = mcd_pkg::EV_MOVE;
                    res0.total_x     = sum_x_reg;
                    res0.total_y     = sum_y_reg;
                    res0.total_wheel = sum_wheel_reg;
                    n_res            = 2'd1;
                end
                sum_x_next       = '0;
                sum_y_next       = '0;
                sum_wheel_next   = '0;
                moved_next       = 1'b0;
                click_flags_next = '0;
            end
            default:
            begin
            end
        endcase

        res0.drag_active = drag_next;
        res1.drag_active = drag_next;
        res0.last_of_run = (n_res == 2'd1);
        res1.last_of_run = 1'b1;
    end

    assign res_count = n_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_flags_reg    <= '0;
            click_flags_reg   <= '0;
            drag_button_reg   <= '0;
            pre_drag_reg      <= 1'b0;
            drag_reg          <= 1'b0;
            travel_reg        <= '0;
            last_rel_btn_reg  <= mcd_pkg::NO_BUTTON;
            last_rel_time_reg <= '0;
            sum_x_reg         <= '0;
            sum_y_reg         <= '0;
            sum_wheel_reg     <= '0;
            moved_reg         <= 1'b0;
        end
        else if (advance)
        begin
            held_flags_reg    <= held_flags_next;
            click_flags_reg   <= click_flags_next;
            drag_button_reg   <= drag_button_next;
            pre_drag_reg      <= pre_drag_next;
            drag_reg          <= drag_next;
            travel_reg        <= travel_next;
            last_rel_btn_reg  <= last_rel_btn_next;
            last_rel_time_reg <= last_rel_time_next;
            sum_x_reg         <= sum_x_next;
            sum_y_reg         <= sum_y_next;
            sum_wheel_reg     <= sum_wheel_next;
            moved_reg         <= moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && press_wr)
        begin
            press_times_reg[bidx] <= item.stamp;
        end
    end

    `ASSERT_ALWAYS(a_drag_excl, clk, rst_n, !(drag_reg && pre_drag_reg), "drag and pre-drag both set")
    `ASSERT_NEXT(a_frame_clr, clk, rst_n, advance && (item.operation == mcd_pkg::OP_FRAME), (click_flags_reg == '0) && !moved_reg && (sum_x_reg == '0), "frame end did not clear")
    `ASSERT_NEXT(a_press_held, clk, rst_n, advance && (item.operation == mcd_pkg::OP_BUTTON) && item.pressed && btn_ok, held_flags_reg[$past(bidx)] && click_flags_reg[$past(bidx)], "press did not mark button")
    `ASSERT_ALWAYS(a_two_res, clk, rst_n, (n_res != 2'd2) || ((res0.event_code == mcd_pkg::EV_UP) && (res1.event_code == mcd_pkg::EV_STROKE) && !drag_reg), "bad two-event record")

endmodule

FILE: sv/mouse_click_drag_classifier.sv
// Mouse click / double-click / drag classifier.
// Input channel: in_valid/in_stall with operation, button, pressed, amount
// and stamp; a record transaction completes when in_valid is high and
// in_stall low. Output channel: out_valid/out_stall with one event per
// transaction; each record gives zero, one or two events, the last one
// flagged by last_of_run. Configuration: cfg_valid/cfg_ready with cfg_index
// (0 double-click window, 1 drag hold time, 2 drag travel) and cfg_data;
// cfg_ready is always high, other indexes are dropped.
// A record is captured in an input register, classified from that register
// once the queue has room for two events, and its events are pushed into a
// four-entry output queue whose head event is presented. One record
// per cycle is taken while records give at most one event each and the
// receiver keeps up; a two-event record fills two queue entries at once.
// in_stall rises when the held record cannot push its events because the
// queue has fewer than two free entries. While out_stall is high the head
// event stays unchanged. Reset empties the queue, clears the tracking
// state except press times, and loads config defaults 300, 500 and 2.

`include "assert_macros.svh"

module mouse_click_drag_classifier #(
    parameter int BUTTON_COUNT = mcd_pkg::BUTTON_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  logic [2:0]         button,
    input  logic               pressed,
    input  logic signed [15:0] amount,
    input  logic [31:0]        stamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         event_code,
    output logic [3:0]         event_button,
    output logic signed [15:0] wheel_delta,
    output logic signed [31:0] total_x,
    output logic signed [31:0] total_y,
    output logic signed [31:0] total_wheel,
    output logic               drag_active,
    output logic               last_of_run,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int DEPTH = mcd_pkg::FIFO_DEPTH;
    localparam int PTR_W = mcd_pkg::FIFO_PTR_W;
    localparam int CNT_W = PTR_W + 1;

    mcd_pkg::cfg_t    cfg_reg;
    mcd_pkg::item_t   item_reg;
    logic             item_vld_reg;
    mcd_pkg::result_t res0;
    mcd_pkg::result_t res1;
    logic [1:0]       res_count;
    logic             advance;
    logic [1:0]       push_n;
    logic             pop;

    mcd_pkg::result_t fifo_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    mcd_pkg::result_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dbl_window <= mcd_pkg::DBL_WINDOW_RST;
            cfg_reg.hold_time  <= mcd_pkg::HOLD_TIME_RST;
            cfg_reg.travel     <= mcd_pkg::TRAVEL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mcd_pkg::CFG_DBL_WINDOW: cfg_reg.dbl_window <= cfg_data;
                mcd_pkg::CFG_HOLD_TIME:  cfg_reg.hold_time  <= cfg_data;
                mcd_pkg::CFG_TRAVEL:     cfg_reg.travel     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign advance  = item_vld_reg && (count_reg <= CNT_W'(DEPTH - 2));
    assign in_stall = item_vld_reg && !advance;
    assign push_n   = advance ? res_count : 2'd0;
    assign pop      = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.operation <= operation;
            item_reg.button    <= button;
            item_reg.pressed   <= pressed;
            item_reg.amount    <= amount;
            item_reg.stamp     <= stamp;
        end
    end

    mcd_core #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if ((push_n != 2'd0) && (PTR_W'(i) == wr_ptr_reg))
            begin
                fifo_reg[i] <= res0;
            end
            else if ((push_n == 2'd2) && (PTR_W'(i) == PTR_W'(wr_ptr_reg + 1'b1)))
            begin
                fifo_reg[i] <= res1;
            end
        end
    end

    assign head         = fifo_reg[rd_ptr_reg];
    assign out_valid    = (count_reg != '0);
    assign event_code   = head.event_code;
    assign event_button = head.event_button;
    assign wheel_delta  = head.wheel_delta;
    assign total_x      = head.total_x;
    assign total_y      = head.total_y;
    assign total_wheel  = head.total_wheel;
    assign drag_active  = head.drag_active;
    assign last_of_run  = head.last_of_run;

    `ASSERT_ALWAYS(a_fifo_room, clk, rst_n, !advance || ((CNT_W + 1)'(count_reg) + (CNT_W + 1)'(push_n) <= (CNT_W + 1)'(DEPTH)), "output queue overflow")
    `ASSERT_NEXT(a_stall_holds_item, clk, rst_n, in_stall, item_vld_reg && $stable(item_reg), "held record lost while stalled")

endmodule

FILE: sim/mcd_event_checker.sv
`timescale 1ns / 100ps

module mcd_event_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         operation,
    input  logic [2:0]         button,
    input  logic               pressed,
    input  logic signed [15:0] amount,
    input  logic [31:0]        stamp,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [2:0]         event_code,
    input  logic [3:0]         event_button,
    input  logic signed [15:0] wheel_delta,
    input  logic signed [31:0] total_x,
    input  logic signed [31:0] total_y,
    input  logic signed [31:0] total_wheel,
    input  logic               drag_active,
    input  logic               last_of_run,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 errors,
    output int                 outstanding
);

    logic [15:0]        dbl_cfg;
    logic [15:0]        hold_cfg;
    logic [15:0]        travel_cfg;

    logic [7:0]         held;
    logic [7:0]         clicks;
    logic [31:0]        press_t [8];
    logic [2:0]         drag_btn;
    logic               pre_drag;
    logic               dragging;
    logic [15:0]        travel;
    logic [3:0]         last_rel_btn;
    logic [31:0]        last_rel_t;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_wheel;
    logic               moved;

    mcd_pkg::result_t   staged [2];
    int                 n_staged;
    mcd_pkg::result_t   pending_events [$];

    function automatic logic signed [31:0] clamp_add(logic signed [31:0] a,
                                                     logic signed [15:0] b);
        longint s;
        s = a;
        s = s + b;
        if (s > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (s < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    function automatic int field_diff(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    task automatic add_event(logic [2:0] code, logic [3:0] btn, logic signed [15:0] wd,
                             logic signed [31:0] tx, logic signed [31:0] ty,
                             logic signed [31:0] tw);
        mcd_pkg::result_t r;
        r = '0;
        r.event_code   = code;
        r.event_button = btn;
        r.wheel_delta  = wd;
        r.total_x      = tx;
        r.total_y      = ty;
        r.total_wheel  = tw;
        staged[n_staged] = r;
        n_staged++;
    endtask

    task automatic track_motion(logic signed [15:0] amt, logic [31:0] st);
        int          mag;
        int          t;
        logic [31:0] held_for;
        moved = 1'b1;
        if (pre_drag)
        begin
            mag = (amt < 0) ? -int'(amt) : int'(amt);
            t = int'(travel) + mag;
            travel = (t > 65535) ? 16'hFFFF : t[15:0];
            held_for = st - press_t[drag_btn];
            if (held_for > {16'h0, hold_cfg} || travel >= travel_cfg)
            begin
                pre_drag = 1'b0;
                dragging = 1'b1;
            end
        end
    endtask

    task automatic classify_record(mcd_pkg::item_t it);
        logic        can_stroke;
        logic [31:0] since_rel;
        n_staged = 0;
        case (it.operation)
            mcd_pkg::OP_X:
            begin
                acc_x = clamp_add(acc_x, it.amount);
                track_motion(it.amount, it.stamp);
            end
            mcd_pkg::OP_Y:
            begin
                acc_y = clamp_add(acc_y, it.amount);
                track_motion(it.amount, it.stamp);
            end
            mcd_pkg::OP_WHEEL:
            begin
                acc_wheel = clamp_add(acc_wheel, it.amount);
                add_event(mcd_pkg::EV_WHEEL, mcd_pkg::NO_BUTTON, it.amount, '0, '0, '0);
            end
            mcd_pkg::OP_BUTTON:
            begin
                if (it.button < mcd_pkg::BUTTON_COUNT_DEF)
                begin
                    if (it.pressed)
                    begin
                        held[it.button]    = 1'b1;
                        clicks[it.button]  = 1'b1;
                        press_t[it.button] = it.stamp;
                        if (!dragging)
                        begin
                            drag_btn = it.button;
                            pre_drag = 1'b1;
                            travel   = '0;
                        end
                        add_event(mcd_pkg::EV_DOWN, {1'b0, it.button}, '0, '0, '0, '0);
                    end
                    else
                    begin
                        can_stroke = !dragging;
                        held[it.button] = 1'b0;
                        dragging = 1'b0;
                        pre_drag = 1'b0;
                        since_rel = it.stamp - last_rel_t;
                        if ({1'b0, it.button} == last_rel_btn && since_rel < {16'h0, dbl_cfg})
                        begin
                            add_event(mcd_pkg::EV_DOUBLE, {1'b0, it.button}, '0, '0, '0, '0);
                            last_rel_btn = mcd_pkg::NO_BUTTON;
                        end
                        else
                        begin
                            add_event(mcd_pkg::EV_UP, {1'b0, it.button}, '0, '0, '0, '0);
                            if (can_stroke)
                            begin
                                add_event(mcd_pkg::EV_STROKE, {1'b0, it.button},
                                          '0, '0, '0, '0);
                            end
                            last_rel_btn = {1'b0, it.button};
                            last_rel_t   = it.stamp;
                        end
                    end
                end
            end
            mcd_pkg::OP_FRAME:
            begin
                if (moved)
                begin
                    add_event(mcd_pkg::EV_MOVE, mcd_pkg::NO_BUTTON, '0,
                              acc_x, acc_y, acc_wheel);
                end
                acc_x     = '0;
                acc_y     = '0;
                acc_wheel = '0;
                moved     = 1'b0;
                clicks    = '0;
            end
            default:
            begin
            end
        endcase
        for (int k = 0; k < n_staged; k++)
        begin
            staged[k].drag_active = dragging;
            staged[k].last_of_run = (k == n_staged - 1);
            pending_events.push_back(staged[k]);
        end
    endtask

    always @(posedge clk)
    begin
        mcd_pkg::result_t e;
        mcd_pkg::item_t   it;
        if (!rst_n)
        begin
            dbl_cfg      = mcd_pkg::DBL_WINDOW_RST;
            hold_cfg     = mcd_pkg::HOLD_TIME_RST;
            travel_cfg   = mcd_pkg::TRAVEL_RST;
            held         = '0;
            clicks       = '0;
            for (int i = 0; i < 8; i++)
            begin
                press_t[i] = '0;
            end
            drag_btn     = '0;
            pre_drag     = 1'b0;
            dragging     = 1'b0;
            travel       = '0;
            last_rel_btn = mcd_pkg::NO_BUTTON;
            last_rel_t   = '0;
            acc_x        = '0;
            acc_y        = '0;
            acc_wheel    = '0;
            moved        = 1'b0;
            errors       = 0;
            pending_events.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mcd_pkg::CFG_DBL_WINDOW: dbl_cfg    = cfg_data;
                    mcd_pkg::CFG_HOLD_TIME:  hold_cfg   = cfg_data;
                    mcd_pkg::CFG_TRAVEL:     travel_cfg = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected event code %0d button %0d", $time,
                             event_code, event_button);
                end
                else
                begin
                    e = pending_events.pop_front();
                    errors += field_diff("event_code", e.event_code, event_code);
                    errors += field_diff("event_button", e.event_button, event_button);
                    errors += field_diff("wheel_delta", e.wheel_delta, wheel_delta);
                    errors += field_diff("total_x", e.total_x, total_x);
                    errors += field_diff("total_y", e.total_y, total_y);
                    errors += field_diff("total_wheel", e.total_wheel, total_wheel);
                    errors += field_diff("drag_active", e.drag_active, drag_active);
                    errors += field_diff("last_of_run", e.last_of_run, last_of_run);
                end
            end
            if (in_valid && !in_stall)
            begin
                it.operation = operation;
                it.button    = button;
                it.pressed   = pressed;
                it.amount    = amount;
                it.stamp     = stamp;
                classify_record(it);
            end
            outstanding <= pending_events.size();
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int LIMIT = 2000000;
    localparam int PHASE_ITEMS = 260;
    localparam int SAT_COUNT = 4;

    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;
    localparam logic [1:0] CFG_SPARE  = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         operation;
    logic [2:0]         button;
    logic               pressed;
    logic signed [15:0] amount;
    logic [31:0]        stamp;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         event_code;
    logic [3:0]         event_button;
    logic signed [15:0] wheel_delta;
    logic signed [31:0] total_x;
    logic signed [31:0] total_y;
    logic signed [31:0] total_wheel;
    logic               drag_active;
    logic               last_of_run;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    int                 errors;
    int                 outstanding;
    int                 send_idle;
    int                 recv_stall;
    int                 cycles = 0;
    logic [31:0]        now;

    always #4 clk = ~clk;

    mouse_click_drag_classifier dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .button(button), .pressed(pressed),
        .amount(amount), .stamp(stamp),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_code(event_code), .event_button(event_button),
        .wheel_delta(wheel_delta), .total_x(total_x), .total_y(total_y),
        .total_wheel(total_wheel), .drag_active(drag_active), .last_of_run(last_of_run),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mcd_event_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .button(button), .pressed(pressed),
        .amount(amount), .stamp(stamp),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_code(event_code), .event_button(event_button),
        .wheel_delta(wheel_delta), .total_x(total_x), .total_y(total_y),
        .total_wheel(total_wheel), .drag_active(drag_active), .last_of_run(last_of_run),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_record(logic [2:0] op, logic [2:0] btn, logic prs,
                               logic signed [15:0] amt, logic [31:0] st);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        button    <= btn;
        pressed   <= prs;
        amount    <= amt;
        stamp     <= st;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic apply_settings(logic [15:0] win, logic [15:0] hold, logic [15:0] span);
        logic [15:0] vals [4];
        logic [31:0] j;
        j = $urandom;
        vals[mcd_pkg::CFG_DBL_WINDOW] = win;
        vals[mcd_pkg::CFG_HOLD_TIME]  = hold;
        vals[mcd_pkg::CFG_TRAVEL]     = span;
        vals[CFG_SPARE]               = j[15:0];
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic advance(int max_step);
        if ($urandom_range(99) < 4)
        begin
            now = $urandom;
        end
        else
        begin
            now = now + $urandom_range(0, max_step);
        end
    endtask

    function automatic logic signed [15:0] rnd_amount();
        logic signed [15:0] v;
        logic [31:0]        w;
        if ($urandom_range(99) < 85)
        begin
            w = $urandom_range(0, 16);
            v = w[15:0];
            return v - 16'sd8;
        end
        w = $urandom;
        return w[15:0];
    endfunction

    function automatic logic [2:0] rnd_motion_op();
        return $urandom_range(1) ? mcd_pkg::OP_X : mcd_pkg::OP_Y;
    endfunction

    initial
    begin
        logic [15:0] win_set  [5];
        logic [15:0] hold_set [5];
        logic [15:0] span_set [5];
        logic [31:0] j;
        logic [2:0]  b;
        int          count;
        int          r;
        int          n;
        logic        paused;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = mcd_pkg::OP_X;
        button     = '0;
        pressed    = 1'b0;
        amount     = '0;
        stamp      = '0;
        cfg_valid  = 1'b0;
        cfg_index  = mcd_pkg::CFG_DBL_WINDOW;
        cfg_data   = '0;
        send_idle  = 0;
        recv_stall = 0;
        now        = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset configuration
        send_record(mcd_pkg::OP_FRAME, 3'd0, 1'b0, 16'sd0, 32'd100);
        send_record(mcd_pkg::OP_X, 3'd0, 1'b0, 16'sd32767, 32'd110);
        send_record(mcd_pkg::OP_Y, 3'd7, 1'b1, -16'sd32768, 32'd120);
        send_record(mcd_pkg::OP_WHEEL, 3'd0, 1'b0, 16'sd32767, 32'd130);
        send_record(mcd_pkg::OP_WHEEL, 3'd0, 1'b0, -16'sd32768, 32'd140);
        send_record(mcd_pkg::OP_FRAME, 3'd0, 1'b0, 16'sd0, 32'd150);
        send_record(mcd_pkg::OP_BUTTON, 3'd0, 1'b1, 16'sd0, 32'd1000);
        send_record(mcd_pkg::OP_X, 3'd0, 1'b0, 16'sd1, 32'd1001);
        send_record(mcd_pkg::OP_X, 3'd0, 1'b0, -16'sd1, 32'd1002);
        send_record(mcd_pkg::OP_BUTTON, 3'd1, 1'b1, 16'sd0, 32'd1003);
        send_record(mcd_pkg::OP_BUTTON, 3'd1, 1'b0, 16'sd0, 32'd1010);
        send_record(mcd_pkg::OP_BUTTON, 3'd1, 1'b0, 16'sd0, 32'd1100);
        send_record(mcd_pkg::OP_BUTTON, 3'd2, 1'b1, 16'sd0, 32'd2000);
        send_record(mcd_pkg::OP_BUTTON, 3'd2, 1'b0, 16'sd0, 32'd2100);
        send_record(mcd_pkg::OP_BUTTON, 3'd2, 1'b0, 16'sd0, 32'd2400);
        send_record(mcd_pkg::OP_BUTTON, 3'd7, 1'b1, 16'sd0, 32'hFFFF_FFF0);
        send_record(mcd_pkg::OP_Y, 3'd0, 1'b0, 16'sd0, 32'h0000_0010);
        send_record(mcd_pkg::OP_Y, 3'd0, 1'b0, 16'sd0, 32'h0000_0300);
        send_record(mcd_pkg::OP_BUTTON, 3'd7, 1'b0, 16'sd0, 32'h0000_0400);
        send_record(OP_SPARE_A, 3'd7, 1'b1, -16'sd1, 32'hFFFF_FFFF);
        send_record(OP_SPARE_B, 3'd2, 1'b0, 16'sd5, 32'd7);
        send_record(OP_SPARE_C, 3'd4, 1'b1, 16'sd9, 32'd8);
        send_record(mcd_pkg::OP_FRAME, 3'd0, 1'b0, 16'sd0, 32'h0000_0500);
        drain();

        // travel saturation
        apply_settings(16'd300, 16'hFFFF, 16'hFFFF);
        send_record(mcd_pkg::OP_BUTTON, 3'd3, 1'b1, 16'sd0, 32'd5000);
        for (int i = 0; i < SAT_COUNT; i++)
        begin
            send_record(mcd_pkg::OP_X, 3'd0, 1'b0, 16'sd32767, 32'd5000);
            send_record(mcd_pkg::OP_Y, 3'd0, 1'b0, -16'sd32768, 32'd5000);
        end
        for (int i = 0; i < SAT_COUNT; i++)
        begin
            send_record(mcd_pkg::OP_WHEEL, 3'd0, 1'b0, 16'sd32767, 32'd5000);
        end
        send_record(mcd_pkg::OP_FRAME, 3'd0, 1'b0, 16'sd0, 32'd5001);
        send_record(mcd_pkg::OP_BUTTON, 3'd3, 1'b0, 16'sd0, 32'd5002);
        drain();

        win_set[0]  = mcd_pkg::DBL_WINDOW_RST;
        hold_set[0] = mcd_pkg::HOLD_TIME_RST;
        span_set[0] = mcd_pkg::TRAVEL_RST;
        win_set[1]  = 16'd0;
        hold_set[1] = 16'd0;
        span_set[1] = 16'd0;
        win_set[2]  = 16'hFFFF;
        hold_set[2] = 16'hFFFF;
        span_set[2] = 16'hFFFF;
        win_set[3]  = 16'd80;
        hold_set[3] = 16'd150;
        span_set[3] = 16'd12;
        win_set[4]  = 16'($urandom_range(0, 1000));
        hold_set[4] = 16'($urandom_range(0, 1000));
        span_set[4] = 16'($urandom_range(0, 64));

        for (int p = 0; p < 5; p++)
        begin
            apply_settings(win_set[p], hold_set[p], span_set[p]);
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 50; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 50; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            count  = 0;
            paused = 1'b0;
            while (count < PHASE_ITEMS)
            begin
                if (!paused && count > PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                r = $urandom_range(99);
                j = $urandom;
                if (r < 40)
                begin
                    b = j[2:0];
                    advance(600);
                    send_record(mcd_pkg::OP_BUTTON, b, 1'b1, rnd_amount(), now);
                    n = $urandom_range(0, 6);
                    for (int k = 0; k < n; k++)
                    begin
                        j = $urandom;
                        advance(200);
                        send_record(rnd_motion_op(), j[2:0], j[3], rnd_amount(), now);
                    end
                    advance(600);
                    send_record(mcd_pkg::OP_BUTTON, b, 1'b0, rnd_amount(), now);
                    count += n + 2;
                    if ($urandom_range(3) == 0)
                    begin
                        advance(80);
                        send_record(mcd_pkg::OP_BUTTON, b, 1'b1, rnd_amount(), now);
                        advance(80);
                        send_record(mcd_pkg::OP_BUTTON, b, 1'b0, rnd_amount(), now);
                        count += 2;
                    end
                end
                else if (r < 52)
                begin
                    advance(100);
                    send_record(mcd_pkg::OP_WHEEL, j[2:0], j[3], rnd_amount(), now);
                    count++;
                end
                else if (r < 64)
                begin
                    advance(100);
                    send_record(mcd_pkg::OP_FRAME, j[2:0], j[3], rnd_amount(), now);
                    count++;
                end
                else if (r < 80)
                begin
                    advance(100);
                    send_record(rnd_motion_op(), j[2:0], j[3], rnd_amount(), now);
                    count++;
                end
                else if (r < 88)
                begin
                    advance(400);
                    send_record(mcd_pkg::OP_BUTTON, j[2:0], 1'b1, rnd_amount(), now);
                    count++;
                end
                else if (r < 94)
                begin
                    advance(400);
                    send_record(mcd_pkg::OP_BUTTON, j[2:0], 1'b0, rnd_amount(), now);
                    count++;
                end
                else if (r < 97)
                begin
                    send_record(3'($urandom_range(0, 4)), j[2:0], j[3], j[31:16], $urandom);
                    count++;
                end
                else
                begin
                    send_record(3'($urandom_range(5, 7)), j[2:0], j[3], j[31:16], $urandom);
                end
            end
            drain();
        end

        send_idle  = 0;
        recv_stall = 0;
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && outstanding == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: mouse_click_drag_classifier.f
+incdir+sv
sv/mcd_pkg.sv
sv/mcd_core.sv
sv/mouse_click_drag_classifier.sv
sim/mcd_event_checker.sv
sim/tb.sv
